// ===== design/stwb_pkg.sv =====
// Shared types and constants for the two-wire sensor bus master.
// Used by stwb_step and sensor_two_wire_bus_master; depends on nothing.
package stwb_pkg;

	localparam int          RESET_PULSES_DEFAULT = 9;
	localparam logic [15:0] HALF_PERIOD_RESET    = 16'd50;
	localparam int          SC_SECOND_BIT        = 3;
	localparam int          SC_NACK_BIT          = 4;
	localparam logic [4:0]  SC_SECOND            = 5'h08;
	localparam logic [2:0]  BIT_LAST             = 3'd7;
	localparam logic [4:0]  START_STEPS          = 5'd5;
	localparam logic [1:0]  MODE_CMD             = 2'd0;
	localparam logic [1:0]  MODE_WRITE           = 2'd1;
	localparam logic [1:0]  MODE_READ            = 2'd2;
	localparam logic [1:0]  MODE_SPARE           = 2'd3;
	localparam logic [2:0]  ADDR_HALF_PERIOD     = 3'd0;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_RS_HI = 4'd1,
		PH_RS_LO = 4'd2,
		PH_START = 4'd3,
		PH_WR_LO = 4'd4,
		PH_WR_HI = 4'd5,
		PH_WA_LO = 4'd6,
		PH_WA_HI = 4'd7,
		PH_WAIT  = 4'd8,
		PH_RD_HI = 4'd9,
		PH_RD_LO = 4'd10,
		PH_RA_A  = 4'd11,
		PH_RA_B  = 4'd12,
		PH_RA_C  = 4'd13
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  step_count;
		logic [15:0] tick_count;
		logic [7:0]  shift_byte;
		logic [15:0] word_hold;
		logic [1:0]  mode_hold;
		logic [7:0]  command_hold;
		logic [7:0]  data_hold;
		logic        clock_level;
		logic        data_level;
	} bus_state_t;

	typedef struct packed {
		logic        scl_level;
		logic        sda_release;
		logic        busy_res;
		logic        done_res;
		logic        error_code;
		logic [15:0] read_word;
	} bus_result_t;

endpackage

// ===== design/stwb_step.sv =====
// Next-state and result logic for one tick of the two-wire bus master.
// Depends on stwb_pkg.
module stwb_step import stwb_pkg::*; #(
	parameter int RESET_PULSES = RESET_PULSES_DEFAULT
) (
	input  logic [15:0] half_period_ticks,
	input  logic        action,
	input  logic [1:0]  mode,
	input  logic [7:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        sda_in,
	input  bus_state_t  cur,
	output bus_state_t  nxt,
	output bus_result_t res
);

	logic [4:0]  sc_inc;
	logic [15:0] tc_inc;
	logic        second;
	logic        fin;
	logic        fin_err;

	assign sc_inc = 5'(cur.step_count + 5'd1);
	assign tc_inc = 16'(cur.tick_count + 16'd1);
	assign second = cur.step_count[SC_SECOND_BIT];

	always_comb begin
		nxt     = cur;
		fin     = 1'b0;
		fin_err = 1'b0;
		case (cur.phase)
			PH_IDLE: begin
				if (action) begin
					nxt.mode_hold    = mode;
					nxt.command_hold = command;
					nxt.data_hold    = data_byte;
					nxt.word_hold    = '0;
					nxt.shift_byte   = '0;
					nxt.step_count   = '0;
					nxt.tick_count   = '0;
					nxt.clock_level  = 1'b1;
					nxt.data_level   = 1'b1;
					nxt.phase        = PH_RS_HI;
				end
			end
			PH_WAIT: begin
				if (!sda_in) begin
					nxt.tick_count  = '0;
					nxt.shift_byte  = '0;
					nxt.step_count  = '0;
					nxt.clock_level = 1'b1;
					nxt.phase       = PH_RD_HI;
				end
			end
			default: begin
				nxt.tick_count = tc_inc;
				if (tc_inc >= half_period_ticks) begin
					nxt.tick_count = '0;
					case (cur.phase)
						PH_RS_HI: begin
							nxt.clock_level = 1'b0;
							nxt.phase       = PH_RS_LO;
						end
						PH_RS_LO: begin
							nxt.clock_level = 1'b1;
							if (sc_inc < 5'(RESET_PULSES)) begin
								nxt.step_count = sc_inc;
								nxt.phase      = PH_RS_HI;
							end else begin
								nxt.step_count = '0;
								nxt.phase      = PH_START;
							end
						end
						PH_START: begin
							if (cur.step_count >= START_STEPS) begin
								nxt.data_level = cur.command_hold[7];
								nxt.shift_byte = {cur.command_hold[6:0], 1'b0};
								nxt.step_count = '0;
								nxt.phase      = PH_WR_LO;
							end else begin
								nxt.step_count = sc_inc;
								case (sc_inc)
									5'd1:    nxt.data_level  = 1'b0;
									5'd2:    nxt.clock_level = 1'b0;
									5'd3:    nxt.clock_level = 1'b1;
									5'd4:    nxt.data_level  = 1'b1;
									default: nxt.clock_level = 1'b0;
								endcase
							end
						end
						PH_WR_LO: begin
							nxt.clock_level = 1'b1;
							nxt.phase       = PH_WR_HI;
						end
						PH_WR_HI: begin
							nxt.clock_level = 1'b0;
							if (cur.step_count[2:0] < BIT_LAST) begin
								nxt.step_count = sc_inc;
								nxt.data_level = cur.shift_byte[7];
								nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
								nxt.phase      = PH_WR_LO;
							end else begin
								nxt.data_level = 1'b1;
								nxt.phase      = PH_WA_LO;
							end
						end
						PH_WA_LO: begin
							if (sda_in) nxt.step_count[SC_NACK_BIT] = 1'b1;
							nxt.clock_level = 1'b1;
							nxt.phase       = PH_WA_HI;
						end
						PH_WA_HI: begin
							nxt.clock_level = 1'b0;
							if (cur.mode_hold == MODE_WRITE && !cur.step_count[SC_NACK_BIT]
									&& !second) begin
								nxt.data_level = cur.data_hold[7];
								nxt.shift_byte = {cur.data_hold[6:0], 1'b0};
								nxt.step_count = SC_SECOND;
								nxt.phase      = PH_WR_LO;
							end else if (cur.mode_hold == MODE_READ
									&& !cur.step_count[SC_NACK_BIT]) begin
								nxt.step_count = '0;
								nxt.phase      = PH_WAIT;
							end else begin
								fin     = 1'b1;
								fin_err = (cur.mode_hold == MODE_WRITE
									|| cur.mode_hold == MODE_READ)
									&& cur.step_count[SC_NACK_BIT];
							end
						end
						PH_RD_HI: begin
							nxt.clock_level = 1'b0;
							nxt.phase       = PH_RD_LO;
						end
						PH_RD_LO: begin
							if (cur.step_count[2:0] < BIT_LAST) begin
								nxt.step_count  = sc_inc;
								nxt.shift_byte  = {cur.shift_byte[6:0], sda_in};
								nxt.clock_level = 1'b1;
								nxt.phase       = PH_RD_HI;
							end else begin
								nxt.data_level = second;
								nxt.phase      = PH_RA_A;
							end
						end
						PH_RA_A: begin
							nxt.clock_level = 1'b1;
							nxt.phase       = PH_RA_B;
						end
						PH_RA_B: begin
							nxt.clock_level = 1'b0;
							nxt.data_level  = 1'b1;
							nxt.phase       = PH_RA_C;
						end
						PH_RA_C: begin
							if (!second) begin
								nxt.word_hold   = {cur.shift_byte, 8'h00};
								nxt.shift_byte  = {7'd0, sda_in};
								nxt.step_count  = SC_SECOND;
								nxt.clock_level = 1'b1;
								nxt.phase       = PH_RD_HI;
							end else begin
								nxt.word_hold = cur.word_hold | {8'h00, cur.shift_byte};
								fin           = 1'b1;
							end
						end
						default: fin = 1'b1;
					endcase
					if (fin) begin
						nxt.phase       = PH_IDLE;
						nxt.step_count  = '0;
						nxt.tick_count  = '0;
						nxt.clock_level = 1'b0;
						nxt.data_level  = 1'b1;
					end
				end
			end
		endcase
	end

	always_comb begin
		res.scl_level   = nxt.clock_level;
		res.sda_release = nxt.data_level;
		res.busy_res    = (nxt.phase != PH_IDLE);
		res.done_res    = fin;
		res.error_code  = fin & fin_err;
		res.read_word   = (fin && !fin_err && nxt.mode_hold == MODE_READ) ?
			nxt.word_hold : 16'd0;
	end

endmodule

// ===== design/sensor_two_wire_bus_master.sv =====
// Top level of the two-wire sensor bus master: stream ports, register port, state registers.
// Depends on stwb_pkg and stwb_step.
//
// Every input item is one bus tick and yields exactly one result item holding the line
// levels and status after that tick. An item is taken whenever s_tready is high, and its
// result appears in the output register in the cycle after acceptance. s_tready is high
// whenever the output register is empty or its item is taken in the same cycle, so the
// sustained rate is one item per cycle while m_tready stays high, limited only by the
// single output register. A transaction sends RESET_PULSES reset clock pulses, the start
// pattern, the command byte and, by mode, a data byte or a 16-bit read; each line level
// lasts half_period_ticks ticks (register read at paddr 0, written at paddr 0 to 3, reset
// value 50). The read waits for the sensor to pull the data line low with no timeout.
module sensor_two_wire_bus_master import stwb_pkg::*; #(
	parameter int RESET_PULSES = RESET_PULSES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[0], mode[2:1], command[10:3], data_byte[18:11], sda_in[19], zero[23:20]
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_level[0], sda_release[1], busy_res[2], done_res[3], error_code[4],
	// read_word[20:5], zero[23:21]
	output logic [23:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] half_period_q;
	bus_state_t  state_q;
	bus_state_t  state_nxt;
	bus_result_t res_nxt;
	bus_result_t res_q;
	logic        m_tvalid_q;
	logic        s_fire;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_HALF_PERIOD) ? {16'd0, half_period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ADDR_HALF_PERIOD[2]) begin
			half_period_q <= pwdata[15:0];
		end
	end

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	stwb_step #(
		.RESET_PULSES(RESET_PULSES)
	) u_step (
		.half_period_ticks(half_period_q),
		.action           (s_tdata[0]),
		.mode             (s_tdata[2:1]),
		.command          (s_tdata[10:3]),
		.data_byte        (s_tdata[18:11]),
		.sda_in           (s_tdata[19]),
		.cur              (state_q),
		.nxt              (state_nxt),
		.res              (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_IDLE;
			state_q.step_count   <= '0;
			state_q.tick_count   <= '0;
			state_q.shift_byte   <= '0;
			state_q.word_hold    <= '0;
			state_q.mode_hold    <= '0;
			state_q.command_hold <= '0;
			state_q.data_hold    <= '0;
			state_q.clock_level  <= 1'b0;
			state_q.data_level   <= 1'b1;
			m_tvalid_q           <= 1'b0;
		end else begin
			if (s_fire) state_q <= state_nxt;
			if (s_fire) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) res_q <= res_nxt;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'd0, res_q.read_word, res_q.error_code, res_q.done_res,
		res_q.busy_res, res_q.sda_release, res_q.scl_level};

endmodule

// ===== dv/tb_sensor_two_wire_bus_master.sv =====
// Self-checking testbench for sensor_two_wire_bus_master: drives bus ticks with random stalls,
// predicts every result item from a tick-accurate bus model and compares field by field.
// Depends on stwb_pkg and the sensor_two_wire_bus_master RTL.
`timescale 1ns / 100ps

module tb_sensor_two_wire_bus_master import stwb_pkg::*; ();

	localparam int IDLE_LIMIT = 1000;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	sensor_two_wire_bus_master uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	logic [23:0]  tick_q[$];
	bus_result_t  line_q[$];
	int           mismatches = 0;
	bit           calm = 1'b0;

	// bus model state
	phase_t      ph;
	logic [4:0]  stp;
	logic [15:0] tck, hp, wrd;
	logic [7:0]  shf, cmd_h, dat_h;
	logic [1:0]  mode_h;
	logic        scl_q, sda_q, fin, fin_err;

	task automatic bus_clear();
		hp = HALF_PERIOD_RESET;
		ph = PH_IDLE;
		stp = '0;
		tck = '0;
		shf = '0;
		wrd = '0;
		mode_h = '0;
		cmd_h = '0;
		dat_h = '0;
		scl_q = 1'b0;
		sda_q = 1'b1;
		fin = 1'b0;
		fin_err = 1'b0;
	endtask

	task automatic bus_finish(input logic err);
		ph = PH_IDLE;
		stp = '0;
		tck = '0;
		scl_q = 1'b0;
		sda_q = 1'b1;
		fin = 1'b1;
		fin_err = err;
	endtask

	task automatic bus_write_start(input logic [7:0] b, input logic second);
		sda_q = b[7];
		shf = {b[6:0], 1'b0};
		stp = second ? SC_SECOND : 5'd0;
		ph = PH_WR_LO;
	endtask

	task automatic bus_read_start(input logic sda, input logic second);
		shf = {7'd0, sda};
		stp = second ? SC_SECOND : 5'd0;
		scl_q = 1'b1;
		ph = PH_RD_HI;
	endtask

	task automatic bus_level_end(input logic sda);
		logic [2:0] cnt;
		logic       second;
		cnt = stp[2:0];
		second = stp[SC_SECOND_BIT];
		case (ph)
			PH_RS_HI: begin
				scl_q = 1'b0;
				ph = PH_RS_LO;
			end
			PH_RS_LO: begin
				stp = stp + 5'd1;
				scl_q = 1'b1;
				if (stp < RESET_PULSES_DEFAULT) begin
					ph = PH_RS_HI;
				end else begin
					stp = '0;
					ph = PH_START;
				end
			end
			PH_START: begin
				if (stp >= START_STEPS) begin
					bus_write_start(cmd_h, 1'b0);
				end else begin
					stp = stp + 5'd1;
					case (stp)
						5'd1: sda_q = 1'b0;
						5'd2: scl_q = 1'b0;
						5'd3: scl_q = 1'b1;
						5'd4: sda_q = 1'b1;
						default: scl_q = 1'b0;
					endcase
				end
			end
			PH_WR_LO: begin
				scl_q = 1'b1;
				ph = PH_WR_HI;
			end
			PH_WR_HI: begin
				scl_q = 1'b0;
				if (cnt < BIT_LAST) begin
					stp = stp + 5'd1;
					sda_q = shf[7];
					shf = {shf[6:0], 1'b0};
					ph = PH_WR_LO;
				end else begin
					sda_q = 1'b1;
					ph = PH_WA_LO;
				end
			end
			PH_WA_LO: begin
				if (sda)
					stp[SC_NACK_BIT] = 1'b1;
				scl_q = 1'b1;
				ph = PH_WA_HI;
			end
			PH_WA_HI: begin
				scl_q = 1'b0;
				if (mode_h == MODE_WRITE) begin
					if (stp[SC_NACK_BIT])
						bus_finish(1'b1);
					else if (!second)
						bus_write_start(dat_h, 1'b1);
					else
						bus_finish(1'b0);
				end else if (mode_h == MODE_READ) begin
					if (stp[SC_NACK_BIT]) begin
						bus_finish(1'b1);
					end else begin
						stp = '0;
						ph = PH_WAIT;
					end
				end else begin
					bus_finish(1'b0);
				end
			end
			PH_RD_HI: begin
				scl_q = 1'b0;
				ph = PH_RD_LO;
			end
			PH_RD_LO: begin
				if (cnt < BIT_LAST) begin
					stp = stp + 5'd1;
					shf = {shf[6:0], sda};
					scl_q = 1'b1;
					ph = PH_RD_HI;
				end else begin
					sda_q = second;
					ph = PH_RA_A;
				end
			end
			PH_RA_A: begin
				scl_q = 1'b1;
				ph = PH_RA_B;
			end
			PH_RA_B: begin
				scl_q = 1'b0;
				sda_q = 1'b1;
				ph = PH_RA_C;
			end
			PH_RA_C: begin
				if (!second) begin
					wrd = {shf, 8'h00};
					bus_read_start(sda, 1'b1);
				end else begin
					wrd = wrd | {8'h00, shf};
					bus_finish(1'b0);
				end
			end
			default: bus_finish(1'b0);
		endcase
	endtask

	task automatic bus_tick(input logic [23:0] item, output bus_result_t r);
		logic       act, sda;
		logic [1:0] md;
		logic [7:0] c, d;
		{sda, d, c, md, act} = item[19:0];
		fin = 1'b0;
		fin_err = 1'b0;
		if (ph == PH_IDLE) begin
			if (act) begin
				mode_h = md;
				cmd_h = c;
				dat_h = d;
				wrd = '0;
				shf = '0;
				stp = '0;
				tck = '0;
				scl_q = 1'b1;
				sda_q = 1'b1;
				ph = PH_RS_HI;
			end
		end else if (ph == PH_WAIT) begin
			if (!sda) begin
				tck = '0;
				bus_read_start(1'b0, 1'b0);
			end
		end else begin
			tck = tck + 16'd1;
			if (tck >= hp) begin
				tck = '0;
				bus_level_end(sda);
			end
		end
		r.scl_level = scl_q;
		r.sda_release = sda_q;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = fin;
		r.error_code = fin & fin_err;
		r.read_word = (fin && !fin_err && mode_h == MODE_READ) ? wrd : 16'd0;
	endtask

	function automatic logic [23:0] pack_tick(input logic act, input logic [1:0] md,
			input logic [7:0] c, input logic [7:0] d, input logic sda);
		return {4'd0, sda, d, c, md, act};
	endfunction

	function automatic logic sda_level(input int low_pct);
		return $urandom_range(0, 99) >= low_pct;
	endfunction

	// ticks
	logic        nxt_v;
	logic [23:0] nxt_d;
	int          src_gap;
	bus_result_t res;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			src_gap <= 0;
		end else begin
			nxt_v = s_tvalid;
			nxt_d = s_tdata;
			if (s_tvalid && s_tready) begin
				bus_tick(s_tdata, res);
				line_q.push_back(res);
				nxt_v = 1'b0;
			end
			if (!nxt_v) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					src_gap <= $urandom_range(0, 3);
				end else if (tick_q.size() > 0) begin
					nxt_v = 1'b1;
					nxt_d = tick_q.pop_front();
				end
			end
			s_tvalid <= nxt_v;
			s_tdata <= nxt_d;
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	int          sink_gap;
	bus_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (line_q.size() == 0) begin
					$error("result item with nothing expected: %h", m_tdata);
					mismatches++;
				end else begin
					want = line_q.pop_front();
					check_field("scl_level", 16'(want.scl_level), 16'(m_tdata[0]));
					check_field("sda_release", 16'(want.sda_release), 16'(m_tdata[1]));
					check_field("busy_res", 16'(want.busy_res), 16'(m_tdata[2]));
					check_field("done_res", 16'(want.done_res), 16'(m_tdata[3]));
					check_field("error_code", 16'(want.error_code), 16'(m_tdata[4]));
					check_field("read_word", want.read_word, m_tdata[20:5]);
				end
			end
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				sink_gap <= $urandom_range(0, 3);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic drain();
		do @(negedge clk);
		while (tick_q.size() != 0 || s_tvalid || line_q.size() != 0);
	endtask

	task automatic cfg_write(input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_HALF_PERIOD;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		hp = value;
	endtask

	task automatic gen_txn(input logic [1:0] md, input logic [7:0] c, input logic [7:0] d,
			input int len, input int low_pct, input bit noisy);
		tick_q.push_back(pack_tick(1'b1, md, c, d, sda_level(low_pct)));
		repeat (len) begin
			if (noisy)
				tick_q.push_back(pack_tick($urandom_range(0, 29) == 0,
					2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), sda_level(low_pct)));
			else
				tick_q.push_back(pack_tick(1'b0, md, c, d, sda_level(low_pct)));
		end
	endtask

	task automatic random_phase(input logic [15:0] h, input int n_txn);
		int he, pick, len;
		int pcts[4];
		logic [1:0] md;
		pcts = '{100, 90, 75, 50};
		he = (h == 16'd0) ? 1 : int'(h);
		drain();
		cfg_write(h);
		repeat (n_txn) begin
			pick = $urandom_range(0, 9);
			md = (pick == 0) ? MODE_CMD : (pick == 1) ? MODE_SPARE :
				(pick < 6) ? MODE_WRITE : MODE_READ;
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(5, 40);
			else
				len = he * 95 + $urandom_range(0, 40);
			gen_txn(md, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
				pcts[$urandom_range(0, 3)], 1'b1);
		end
	endtask

	initial begin
		bus_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		tick_q.push_back(pack_tick(1'b0, MODE_SPARE, 8'hFF, 8'hFF, 1'b1));
		tick_q.push_back(pack_tick(1'b0, MODE_CMD, 8'h00, 8'h00, 1'b0));
		tick_q.push_back(pack_tick(1'b1, MODE_SPARE, 8'hA5, 8'h5A, 1'b0));
		tick_q.push_back(pack_tick(1'b1, MODE_WRITE, 8'h00, 8'hFF, 1'b1));
		repeat (4)
			tick_q.push_back(pack_tick(1'b0, MODE_READ, 8'hFF, 8'h00, 1'b0));

		// zero half period runs the pending transaction out at one tick per level
		drain();
		cfg_write(16'd0);
		repeat (45)
			tick_q.push_back(pack_tick(1'b0, MODE_CMD, 8'h00, 8'h00, 1'b0));
		gen_txn(MODE_READ, 8'h3C, 8'hC3, 90, 75, 1'b0);

		drain();
		cfg_write(16'd1);
		gen_txn(MODE_CMD, 8'hFF, 8'h00, 45, 0, 1'b0);
		gen_txn(MODE_WRITE, 8'h00, 8'hFF, 70, 100, 1'b0);
		gen_txn(MODE_WRITE, 8'hFF, 8'h00, 45, 0, 1'b0);
		gen_txn(MODE_READ, 8'h81, 8'h7E, 45, 0, 1'b0);
		gen_txn(MODE_READ, 8'h55, 8'hAA, 100, 75, 1'b0);

		drain();
		cfg_write(16'hFFFF);
		gen_txn(MODE_READ, 8'h5A, 8'hA5, 30, 100, 1'b0);

		random_phase(16'd2, 1);
		drain();
		calm = 1'b1;
		random_phase(16'd1, 1);
		drain();
		repeat (4) @(posedge clk);

		if (line_q.size() != 0) begin
			$error("%0d result items never arrived", line_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
design/stwb_pkg.sv
design/stwb_step.sv
design/sensor_two_wire_bus_master.sv
dv/tb_sensor_two_wire_bus_master.sv
